### hdl/lst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lst_pkg
// Shared types and constants for the sighting table: the stored entry, the
// search token that walks the row of cells and the update command.
// ----------------------------------------------------------------------------
package lst_pkg;

  localparam int unsigned KeyW    = 48;
  localparam int unsigned CountW  = 16;
  localparam int unsigned StrW    = 8;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned HeldW   = 6;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [CountW-1:0] count;
    logic [StrW-1:0]   strength;
    logic [TimeW-1:0]  first_time;
    logic [TimeW-1:0]  last_time;
  } entry_t;

  // Search token: the first matching entry and the oldest valid entry so far.
  typedef struct packed {
    logic              found;
    logic [CountW-1:0] count;
    logic [StrW-1:0]   strength;
    logic [TimeW-1:0]  first_time;
    logic [TimeW-1:0]  last_time;
    logic              min_set;
    logic [TimeW-1:0]  min_time;
  } token_t;

  typedef enum logic [1:0] {
    UPD_NONE   = 2'd0,
    UPD_HIT    = 2'd1,
    UPD_APPEND = 2'd2,
    UPD_EVICT  = 2'd3
  } upd_op_e;

  typedef struct packed {
    upd_op_e          op;
    logic [KeyW-1:0]  key;
    logic [StrW-1:0]  strength;
    logic [TimeW-1:0] now;
  } cmd_t;

endpackage
`default_nettype wire

### hdl/lst_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lst_cell
// One table entry. Passes the search token on to the next cell each cycle
// and applies the broadcast update command to its own entry.
// ----------------------------------------------------------------------------
module lst_cell #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned IW   = 5,
  parameter int unsigned CW   = 6,
  parameter bit          LAST = 1'b0
) (
  input  wire                    clk_i,
  input  wire [CW-1:0]           count_i,
  input  wire [lst_pkg::KeyW-1:0] key_i,
  input  lst_pkg::token_t        tok_i,
  input  wire [IW-1:0]           hit_idx_i,
  input  wire [IW-1:0]           min_idx_i,
  output lst_pkg::token_t        tok_o,
  output logic [IW-1:0]          hit_idx_o,
  output logic [IW-1:0]          min_idx_o,
  input  lst_pkg::cmd_t          cmd_i,
  input  wire [IW-1:0]           tgt_i,
  input  lst_pkg::entry_t        next_i,
  output lst_pkg::entry_t        entry_o
);
  import lst_pkg::*;

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  entry_t      entry_q, entry_d;
  token_t      tok_q, tok_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d, min_idx_q, min_idx_d;
  logic        valid, match;

  assign valid = count_i > CW'(IDX);
  assign match = valid && (entry_q.key == key_i);

  always_comb begin
    tok_d     = tok_i;
    hit_idx_d = hit_idx_i;
    min_idx_d = min_idx_i;
    if (!tok_i.found && match) begin
      tok_d.found      = 1'b1;
      tok_d.count      = entry_q.count;
      tok_d.strength   = entry_q.strength;
      tok_d.first_time = entry_q.first_time;
      tok_d.last_time  = entry_q.last_time;
      hit_idx_d        = MyIdx;
    end
    // Strictly smaller only, so ties stay with the lower position.
    if (valid && (!tok_i.min_set || entry_q.last_time < tok_i.min_time)) begin
      tok_d.min_set  = 1'b1;
      tok_d.min_time = entry_q.last_time;
      min_idx_d      = MyIdx;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q     <= tok_d;
    hit_idx_q <= hit_idx_d;
    min_idx_q <= min_idx_d;
  end

  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i.op)
      UPD_HIT: begin
        if (tgt_i == MyIdx) begin
          if (entry_q.count != CountMax) entry_d.count = entry_q.count + 1'b1;
          entry_d.last_time = cmd_i.now;
          if ($signed(cmd_i.strength) > $signed(entry_q.strength)) begin
            entry_d.strength = cmd_i.strength;
          end
        end
      end
      UPD_APPEND: begin
        if (tgt_i == MyIdx) begin
          entry_d = '{key: cmd_i.key, count: CountW'(1), strength: cmd_i.strength,
                      first_time: cmd_i.now, last_time: cmd_i.now};
        end
      end
      UPD_EVICT: begin
        // Entries above the evicted one move down; the new one lands at the end.
        if (LAST) begin
          entry_d = '{key: cmd_i.key, count: CountW'(1), strength: cmd_i.strength,
                      first_time: cmd_i.now, last_time: cmd_i.now};
        end else if (MyIdx >= tgt_i) begin
          entry_d = next_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign tok_o     = tok_q;
  assign hit_idx_o = hit_idx_q;
  assign min_idx_o = min_idx_q;
  assign entry_o   = entry_q;

endmodule
`default_nettype wire

### hdl/lru_sighting_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_sighting_table_core
// Station sighting table with oldest-entry eviction, built as a row of cells.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata (low bit up)                           tuser
// s_axis    in   station_address, signal_strength, now_time   req_type
// m_axis    out  times_seen, best_strength, first_seen,       is_new, hit
//                last_seen, entries_held, zero pad
//
// The search token ripples through the cells while the core is in its scan
// state; the update state then updates the entries and loads the output
// register. Ready is high only when idle, so a new request is not taken
// until the previous one has passed its update state.
// The update waits while a previous result is still held in the output register.
// Reset empties the table at once; entry contents need no clearing.
// ----------------------------------------------------------------------------
module lru_sighting_table_core #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [87:0] s_axis_tdata_i,  // station_address, signal_strength, now_time
  input  wire         s_axis_tuser_i,  // req_type
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o,  // times_seen, best_strength, first_seen,
                                       // last_seen, entries_held, pad
  output logic [1:0]  m_axis_tuser_o   // is_new, hit
);
  import lst_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_UPDATE = 4'b0100,
    S_SPARE  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [IW-1:0] scan_q, scan_d;
  logic [CW-1:0] count_q, count_d;
  logic          query_q;
  logic [KeyW-1:0]  key_q;
  logic [StrW-1:0]  str_q;
  logic [TimeW-1:0] now_q;
  logic          out_valid_q;
  logic [95:0]   out_data_q, out_data_d;
  logic [1:0]    out_user_q, out_user_d;

  token_t        tok   [TABLE_DEPTH+1];
  logic [IW-1:0] hidx  [TABLE_DEPTH+1];
  logic [IW-1:0] midx  [TABLE_DEPTH+1];
  entry_t        entry [TABLE_DEPTH];
  cmd_t          cmd;
  logic [IW-1:0] tgt;
  logic          upd_fire, in_fire, full, found;
  token_t        fin;
  logic [CountW-1:0] r_count;
  logic [StrW-1:0]   r_str;
  logic [TimeW-1:0]  r_first, r_last;
  logic              r_new;

  assign tok[0]  = '0;
  assign hidx[0] = '0;
  assign midx[0] = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    lst_cell #(
      .IDX (g),
      .IW  (IW),
      .CW  (CW),
      .LAST(g == TABLE_DEPTH - 1)
    ) u_cell (
      .clk_i    (clk_i),
      .count_i  (count_q),
      .key_i    (key_q),
      .tok_i    (tok[g]),
      .hit_idx_i(hidx[g]),
      .min_idx_i(midx[g]),
      .tok_o    (tok[g+1]),
      .hit_idx_o(hidx[g+1]),
      .min_idx_o(midx[g+1]),
      .cmd_i    (cmd),
      .tgt_i    (tgt),
      .next_i   (entry[(g == TABLE_DEPTH - 1) ? g : g + 1]),
      .entry_o  (entry[g])
    );
  end

  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign upd_fire        = (state_q == S_UPDATE) && (!out_valid_q || m_axis_tready_i);
  assign fin             = tok[TABLE_DEPTH];
  assign found           = fin.found;
  assign full            = (count_q == CW'(TABLE_DEPTH));

  always_comb begin
    cmd.key      = key_q;
    cmd.strength = str_q;
    cmd.now      = now_q;
    cmd.op       = UPD_NONE;
    tgt          = hidx[TABLE_DEPTH];
    count_d      = count_q;
    r_new        = 1'b0;
    r_count      = '0;
    r_str        = '0;
    r_first      = '0;
    r_last       = '0;
    if (found) begin
      r_count = fin.count;
      r_str   = fin.strength;
      r_first = fin.first_time;
      r_last  = fin.last_time;
    end
    if (!query_q) begin
      if (found) begin
        cmd.op = UPD_HIT;
        if (fin.count != CountMax) r_count = fin.count + 1'b1;
        if ($signed(str_q) > $signed(fin.strength)) r_str = str_q;
        r_last = now_q;
      end else begin
        r_new   = 1'b1;
        r_count = CountW'(1);
        r_str   = str_q;
        r_first = now_q;
        r_last  = now_q;
        if (full) begin
          cmd.op = UPD_EVICT;
          tgt    = midx[TABLE_DEPTH];
        end else begin
          cmd.op  = UPD_APPEND;
          tgt     = count_q[IW-1:0];
          count_d = count_q + 1'b1;
        end
      end
    end
    if (!upd_fire) begin
      cmd.op  = UPD_NONE;
      count_d = count_q;
    end
    out_user_d = {found, r_new};
    out_data_d = {2'b00, HeldW'(count_d), r_last, r_first, r_str, r_count};
  end

  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    unique case (state_q)
      S_IDLE: begin
        scan_d = '0;
        if (in_fire) state_d = S_SCAN;
      end
      S_SCAN: begin
        scan_d = scan_q + 1'b1;
        if (scan_q == IW'(TABLE_DEPTH - 1)) state_d = S_UPDATE;
      end
      S_UPDATE: begin
        if (upd_fire) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scan_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      count_q <= count_d;
      if (upd_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      query_q <= s_axis_tuser_i;
      key_q   <= s_axis_tdata_i[47:0];
      str_q   <= s_axis_tdata_i[55:48];
      now_q   <= s_axis_tdata_i[87:56];
    end
    if (upd_fire) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule
`default_nettype wire
